@@ sv/adc_percent_lcd_byte_stream_macros.svh @@
// assertion macros for the lcd byte stream block
// used by the top level only, clocked on aclk with reset aresetn
`ifndef ADC_PERCENT_LCD_BYTE_STREAM_MACROS_SVH
`define ADC_PERCENT_LCD_BYTE_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ADCPLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define ADCPLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ADCPLCD_ASSERT(lbl, prop, msg)

`define ADCPLCD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/adcplcd_pkg.sv @@
// shared types and constants for the lcd byte stream block
// no dependencies
package adcplcd_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ADC  = 2'd2;

    // expander control bits: backlight, enable, rs
    localparam logic [7:0] NIB_MASK  = 8'hF0;
    localparam logic [7:0] CMD_EN_HI = 8'h0C;
    localparam logic [7:0] CMD_EN_LO = 8'h08;
    localparam logic [7:0] DAT_EN_HI = 8'h0D;
    localparam logic [7:0] DAT_EN_LO = 8'h09;

    localparam logic [11:0] ADC_FULL  = 12'd4095;
    localparam logic [18:0] PCT_SCALE = 19'd100;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // one queued job: up to four characters, first in chars[0]
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            is_data;
    } job_t;

endpackage

@@ sv/adc_percent_lcd_byte_stream.sv @@
// path: an item passes front-end stages 1 and 2, the queue and the serialiser output
// throughput: one input transaction per cycle into front end and queue, unless a full queue
//   stalls it; the serialiser sends one byte per cycle while m_tready is high, so a command
//   or data item is 4 bytes and an adc item 12 or 16; its byte rate sets the sustained rate
// reset: synchronous, active low on aresetn; clears pipeline valids, queue and serialiser
// depends on adcplcd_pkg, adcplcd_front, adcplcd_queue, adcplcd_back and the macro header
`include "adc_percent_lcd_byte_stream_macros.svh"

module adc_percent_lcd_byte_stream #(
    parameter int QUEUE_DEPTH = 4   // jobs held between front end and serialiser, 2 or more
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // expander bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] expander_byte
    output logic        m_tlast
);

    // front end to queue
    logic              front_valid;
    logic              front_ready;
    adcplcd_pkg::job_t front_job;

    // queue to serialiser
    logic              q_valid;
    logic              q_ready;
    adcplcd_pkg::job_t q_job;

    // front end: two register stages for the percentage, then a character job
    adcplcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // decouples the front end from the slow byte serialiser
    adcplcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_job   (front_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    // back end: nibble and enable sequencing into the output register
    adcplcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // an enable-high byte is always followed by its enable-low partner with the same nibble
    `ADCPLCD_ASSERT_NEXT(a_en_pair, m_tvalid && m_tready && m_tdata[2], m_tvalid && !m_tdata[2] && m_tdata[7:4] == $past(m_tdata[7:4]) && m_tdata[0] == $past(m_tdata[0]), "enable pulse broken")
    // the final byte of a transaction closes an enable pulse
    `ADCPLCD_ASSERT(a_last_en_low, !(m_tvalid && m_tlast && m_tdata[2]), "last byte with enable high")
    // backlight stays on for every byte
    `ADCPLCD_ASSERT(a_backlight, !m_tvalid || m_tdata[3], "backlight bit clear")

endmodule

@@ sv/adcplcd_front.sv @@
// front end: accepts items, works out the percentage and builds character jobs
// depends on adcplcd_pkg
module adcplcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [11:0] value, rest zero
    input  logic [1:0]         s_tuser,   // [1:0] kind
    output logic               job_valid,
    input  logic               job_ready,
    output adcplcd_pkg::job_t  job
);

    logic        adv;
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_kind_reg;
    logic [7:0]  s1_byte_reg;
    logic [18:0] s1_prod_reg, s1_prod_next;
    logic [11:0] diff;

    logic        s2_valid_reg;
    logic [1:0]  s2_kind_reg;
    logic [7:0]  s2_byte_reg;
    logic [6:0]  s2_pct_reg, s2_pct_next;
    logic [6:0]  q0;
    logic [12:0] rem;

    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [7:0]  tens_ch, ones_ch;

    assign adv       = !s2_valid_reg || job_ready;
    assign s_tready  = adv;
    assign job_valid = s2_valid_reg;

    // stage 1: scaled complement of the sample
    assign diff          = adcplcd_pkg::ADC_FULL - s_tdata[11:0];
    assign s1_prod_next  = {7'd0, diff} * adcplcd_pkg::PCT_SCALE;
    assign s1_valid_next = s_tvalid && (s_tuser inside {adcplcd_pkg::KIND_CMD,
                           adcplcd_pkg::KIND_DATA, adcplcd_pkg::KIND_ADC});

    // stage 2: divide by 4095 as x/4096 plus one correction step
    assign q0          = s1_prod_reg[18:12];
    assign rem         = {1'b0, s1_prod_reg[11:0]} + {6'd0, q0};
    assign s2_pct_next = q0 + {6'd0, (rem >= 13'd4095)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_kind_reg <= s_tuser;
            s1_byte_reg <= s_tdata[7:0];
            s1_prod_reg <= s1_prod_next;
            s2_kind_reg <= s1_kind_reg;
            s2_byte_reg <= s1_byte_reg;
            s2_pct_reg  <= s2_pct_next;
        end
    end

    // decimal digits of a percentage below 100
    always_comb begin
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (s2_pct_reg >= 7'(k * 10)) tens = 4'(k);
        end
        ones_full = s2_pct_reg - {tens, 3'b000} - {2'b00, tens, 1'b0};
        tens_ch   = adcplcd_pkg::CH_ZERO + {4'd0, tens};
        ones_ch   = adcplcd_pkg::CH_ZERO + {4'd0, ones_full[3:0]};
    end

    always_comb begin
        job.chars    = {4{s2_byte_reg}};
        job.last_idx = 2'd0;
        job.is_data  = 1'b1;
        case (s2_kind_reg)
            adcplcd_pkg::KIND_CMD: begin
                job.is_data = 1'b0;
            end
            adcplcd_pkg::KIND_DATA: begin
                job.is_data = 1'b1;
            end
            default: begin
                if (s2_pct_reg == 7'd100) begin
                    job.chars    = {adcplcd_pkg::CH_PCT, adcplcd_pkg::CH_ZERO,
                                    adcplcd_pkg::CH_ZERO, adcplcd_pkg::CH_ONE};
                    job.last_idx = 2'd3;
                end else if (s2_pct_reg >= 7'd10) begin
                    job.chars    = {adcplcd_pkg::CH_SPACE, adcplcd_pkg::CH_PCT,
                                    ones_ch, tens_ch};
                    job.last_idx = 2'd2;
                end else begin
                    job.chars    = {adcplcd_pkg::CH_SPACE, adcplcd_pkg::CH_SPACE,
                                    adcplcd_pkg::CH_PCT, ones_ch};
                    job.last_idx = 2'd2;
                end
            end
        endcase
    end

endmodule

@@ sv/adcplcd_queue.sv @@
// small job queue between the front end and the serialiser
// depends on adcplcd_pkg
module adcplcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  adcplcd_pkg::job_t  wr_job,
    output logic               rd_valid,
    input  logic               rd_ready,
    output adcplcd_pkg::job_t  rd_job
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    adcplcd_pkg::job_t entries [DEPTH];
    adcplcd_pkg::job_t rd_job_reg;

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = rd_job_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd) rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd) count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) entries[wr_ptr_reg] <= wr_job;
    end

    // head entry held in a register, taken straight from the write side
    // when the new head is the entry written at this edge
    always_ff @(posedge aclk) begin
        if (do_wr && (wr_ptr_reg == rd_ptr_next)) begin
            rd_job_reg <= wr_job;
        end else begin
            rd_job_reg <= entries[rd_ptr_next];
        end
    end

endmodule

@@ sv/adcplcd_back.sv @@
// serialiser: turns each queued character into four expander bytes
// depends on adcplcd_pkg
module adcplcd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  adcplcd_pkg::job_t  job,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] expander_byte
    output logic               m_tlast
);

    adcplcd_pkg::job_t cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       out_free, finishing, load;
    logic [7:0] ch, nib, ctrl;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign finishing = busy_reg && (phase_reg == 2'd3) && (idx_reg == cur_reg.last_idx);
    assign load      = job_valid && (!busy_reg || (out_free && finishing));
    assign job_ready = load;

    assign ch   = cur_reg.chars[idx_reg];
    assign nib  = phase_reg[1] ? {ch[3:0], 4'd0} : (ch & adcplcd_pkg::NIB_MASK);

    always_comb begin
        case ({cur_reg.is_data, phase_reg[0]})
            2'b00:   ctrl = adcplcd_pkg::CMD_EN_HI;
            2'b01:   ctrl = adcplcd_pkg::CMD_EN_LO;
            2'b10:   ctrl = adcplcd_pkg::DAT_EN_HI;
            default: ctrl = adcplcd_pkg::DAT_EN_LO;
        endcase
    end

    always_comb begin
        cur_next      = cur_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_free) begin
            m_tvalid_next = busy_reg;
            m_tdata_next  = nib | ctrl;
            m_tlast_next  = finishing;
            if (busy_reg) begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd3) idx_next = idx_reg + 1'b1;
                if (finishing) busy_next = 1'b0;
            end
        end
        if (load) begin
            cur_next   = job;
            busy_next  = 1'b1;
            idx_next   = 2'd0;
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 2'd0;
            phase_reg    <= 2'd0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
